>>> rtl/core/aoc_pkg.sv
// Shared types and constants for the alpha-over compositing pipeline.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
package aoc_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int NCH          = 3;                  // red, green, blue
  localparam int WEIGHT_W     = 2 * CHANNEL_BITS;   // alpha weights, scale M^2
  localparam int PM_W         = WEIGHT_W + 1;       // premultiplied sum before rounding
  localparam int NUM_W        = 3 * CHANNEL_BITS;   // straight-mode numerator
  localparam int DIV_STAGES   = CHANNEL_BITS;       // one quotient bit per stage
  localparam int ADDR_W       = 3;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [WEIGHT_W-1:0]     weight_t;

  localparam chan_t FULL_SCALE = '1;
  localparam chan_t HALF_SCALE = FULL_SCALE >> 1;

  typedef enum logic {
    MODE_PREMULT  = 1'b0,
    MODE_STRAIGHT = 1'b1
  } alpha_mode_t;

  // register index, taken from paddr above the byte offset
  localparam logic [ADDR_W-3:0] REG_ALPHA_MODE = '0;

  typedef struct packed {
    chan_t [NCH-1:0] fg;
    chan_t           fg_alpha;
    chan_t [NCH-1:0] bg;
    chan_t           bg_alpha;
  } pair_t;

  // one item in flight through the divider; quo starts as the numerator's low bits
  typedef struct packed {
    weight_t [NCH-1:0] rem;
    chan_t   [NCH-1:0] quo;
    weight_t           dsum;
    logic              dsum_zero;
    chan_t             alpha;
    chan_t   [NCH-1:0] pm;
  } div_data_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pixel_t;

endpackage

>>> rtl/core/aoc_if.sv
// Stream interfaces for the compositing block: the layer pair in and the blended pixel out.
// Depends on aoc_pkg for the channel type.
interface aoc_layers_if;
  logic          valid;
  logic          ready;
  aoc_pkg::chan_t fg_red;
  aoc_pkg::chan_t fg_green;
  aoc_pkg::chan_t fg_blue;
  aoc_pkg::chan_t fg_alpha;
  aoc_pkg::chan_t bg_red;
  aoc_pkg::chan_t bg_green;
  aoc_pkg::chan_t bg_blue;
  aoc_pkg::chan_t bg_alpha;

  modport source (
    output valid, fg_red, fg_green, fg_blue, fg_alpha,
    output bg_red, bg_green, bg_blue, bg_alpha,
    input  ready
  );
  modport sink (
    input  valid, fg_red, fg_green, fg_blue, fg_alpha,
    input  bg_red, bg_green, bg_blue, bg_alpha,
    output ready
  );
endinterface

interface aoc_blend_if;
  logic          valid;
  logic          ready;
  aoc_pkg::chan_t out_red;
  aoc_pkg::chan_t out_green;
  aoc_pkg::chan_t out_blue;
  aoc_pkg::chan_t out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

>>> rtl/core/alpha_over_composite.sv
// Top level of the Porter-Duff over compositor: APB registers, front end, divider, output.
// Depends on aoc_pkg, aoc_if, aoc_apb_regs, aoc_front, aoc_divider, aoc_out_stage.
//
//   channel   kind           direction  payload
//   layers    valid/ready    sink       fg/bg RGBA, 8 x 16 bit
//   blended   valid/ready    source     out RGBA, 4 x 16 bit
//   apb       psel/penable   slave      alpha_mode at byte address 0
//
// One pixel per cycle while the output buffer is not full; 3 front-end stages, 16 divider
// stages (one quotient bit each for the straight-alpha colours), 1 output stage.
// rst (synchronous) clears all valid bits, holds layers.ready low, empties the output
// buffer and selects premultiplied mode. The pipeline holds while the two-entry output
// buffer is full; layers.ready is a decode of that buffer's count.
module alpha_over_composite (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aoc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  aoc_layers_if.sink                 layers,
  aoc_blend_if.source                blended
);

  aoc_pkg::alpha_mode_t mode;
  aoc_pkg::pair_t       pair;
  logic                 en;
  logic                 fe_valid;
  aoc_pkg::div_data_t   fe_data;
  logic                 dv_valid;
  aoc_pkg::div_data_t   dv_data;
  aoc_pkg::pixel_t      px;

  assign pair.fg[0]    = layers.fg_red;
  assign pair.fg[1]    = layers.fg_green;
  assign pair.fg[2]    = layers.fg_blue;
  assign pair.fg_alpha = layers.fg_alpha;
  assign pair.bg[0]    = layers.bg_red;
  assign pair.bg[1]    = layers.bg_green;
  assign pair.bg[2]    = layers.bg_blue;
  assign pair.bg_alpha = layers.bg_alpha;

  assign layers.ready = en && !rst;

  aoc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  aoc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (layers.valid),
    .pair      (pair),
    .out_valid (fe_valid),
    .out_data  (fe_data)
  );

  aoc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fe_valid),
    .in_data   (fe_data),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  aoc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (dv_valid),
    .in_data   (dv_data),
    .ready     (en),
    .out_valid (blended.valid),
    .out_ready (blended.ready),
    .out_pixel (px)
  );

  assign blended.out_red   = px.red;
  assign blended.out_green = px.green;
  assign blended.out_blue  = px.blue;
  assign blended.out_alpha = px.alpha;

endmodule

>>> rtl/core/aoc_apb_regs.sv
// APB-style configuration register file: holds the alpha mode.
// Depends on aoc_pkg.
module aoc_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aoc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output aoc_pkg::alpha_mode_t       mode
);

  logic wr_en;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[aoc_pkg::ADDR_W-1:2] == aoc_pkg::REG_ALPHA_MODE);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= aoc_pkg::MODE_PREMULT;
    end else if (wr_en && hit) begin
      mode <= aoc_pkg::alpha_mode_t'(pwdata[0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[0] = mode;
    end
  end

endmodule

>>> rtl/core/aoc_front.sv
// Front end: alpha weights, numerator products, premultiplied and alpha rounding.
// Three register stages ahead of the divider. Depends on aoc_pkg.
module aoc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  aoc_pkg::pair_t     pair,
  output logic               out_valid,
  output aoc_pkg::div_data_t out_data
);

  localparam int CB       = aoc_pkg::CHANNEL_BITS;
  localparam int NCH      = aoc_pkg::NCH;
  localparam int WW       = aoc_pkg::WEIGHT_W;
  localparam int PM_W     = aoc_pkg::PM_W;
  localparam int NUM_W    = aoc_pkg::NUM_W;
  localparam int Y_W      = PM_W + 1;
  localparam int H_W      = Y_W - CB;
  localparam int T_W      = H_W + 1;
  localparam int FULL_INT = 2**CB - 1;

  // round(x / M) with ties up, saturated to M; y = h*2^CB + l = h*M + (h + l)
  function automatic aoc_pkg::chan_t round_sat(input logic [PM_W-1:0] x);
    logic [Y_W-1:0] y;
    logic [H_W-1:0] h;
    logic [T_W-1:0] t;
    logic [T_W-1:0] q;
    logic [1:0]     k;
    y = {1'b0, x} + Y_W'(aoc_pkg::HALF_SCALE);
    h = y[Y_W-1:CB];
    t = {1'b0, h} + T_W'(y[CB-1:0]);
    if (t >= T_W'(3 * FULL_INT)) begin
      k = 2'd3;
    end else if (t >= T_W'(2 * FULL_INT)) begin
      k = 2'd2;
    end else if (t >= T_W'(FULL_INT)) begin
      k = 2'd1;
    end else begin
      k = 2'd0;
    end
    q = {1'b0, h} + T_W'(k);
    return (q > T_W'(FULL_INT)) ? aoc_pkg::FULL_SCALE : q[CB-1:0];
  endfunction

  // stage 1: weights and premultiplied sums
  aoc_pkg::chan_t                inv;
  aoc_pkg::weight_t              wf_c;
  aoc_pkg::weight_t              wb_c;
  logic [NCH-1:0][PM_W-1:0]      pm_c;

  logic                          s1_valid;
  aoc_pkg::weight_t              s1_wf;
  aoc_pkg::weight_t              s1_wb;
  aoc_pkg::chan_t [NCH-1:0]      s1_fg;
  aoc_pkg::chan_t [NCH-1:0]      s1_bg;
  logic [NCH-1:0][PM_W-1:0]      s1_pm;

  // stage 2: numerator products
  logic                          s2_valid;
  aoc_pkg::weight_t              s2_dsum;
  logic [NCH-1:0][NUM_W-1:0]     s2_pf;
  logic [NCH-1:0][NUM_W-1:0]     s2_pb;
  aoc_pkg::chan_t [NCH-1:0]      s2_pm;

  logic [NCH-1:0][NUM_W-1:0]     num_c;

  always_comb begin
    inv  = aoc_pkg::FULL_SCALE - pair.fg_alpha;
    wf_c = {pair.fg_alpha, {CB{1'b0}}} - WW'(pair.fg_alpha);
    wb_c = WW'(pair.bg_alpha) * WW'(inv);
    for (int c = 0; c < NCH; c++) begin
      pm_c[c] = PM_W'({pair.fg[c], {CB{1'b0}}} - WW'(pair.fg[c]))
              + PM_W'(WW'(pair.bg[c]) * WW'(inv));
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      num_c[c] = s2_pf[c] + s2_pb[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wf <= wf_c;
      s1_wb <= wb_c;
      s1_fg <= pair.fg;
      s1_bg <= pair.bg;
      s1_pm <= pm_c;

      s2_dsum <= s1_wf + s1_wb;
      for (int c = 0; c < NCH; c++) begin
        s2_pf[c] <= NUM_W'(s1_fg[c]) * NUM_W'(s1_wf);
        s2_pb[c] <= NUM_W'(s1_bg[c]) * NUM_W'(s1_wb);
        s2_pm[c] <= round_sat(s1_pm[c]);
      end

      // numerator < 2^CB * dsum, so its top bits start below the divisor
      for (int c = 0; c < NCH; c++) begin
        out_data.rem[c] <= num_c[c][NUM_W-1:CB];
        out_data.quo[c] <= num_c[c][CB-1:0];
      end
      out_data.dsum      <= s2_dsum;
      out_data.dsum_zero <= (s2_dsum == '0);
      out_data.alpha     <= round_sat({1'b0, s2_dsum});
      out_data.pm        <= s2_pm;
    end
  end

endmodule

>>> rtl/core/aoc_divider.sv
// Pipelined restoring divider for the straight-alpha colours, one quotient bit per stage.
// Three channels share each stage's divisor. Depends on aoc_pkg.
module aoc_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  aoc_pkg::div_data_t in_data,
  output logic               out_valid,
  output aoc_pkg::div_data_t out_data
);

  localparam int CB     = aoc_pkg::CHANNEL_BITS;
  localparam int NCH    = aoc_pkg::NCH;
  localparam int WW     = aoc_pkg::WEIGHT_W;
  localparam int STAGES = aoc_pkg::DIV_STAGES;

  function automatic aoc_pkg::div_data_t div_step(input aoc_pkg::div_data_t d);
    aoc_pkg::div_data_t n;
    logic [WW:0]        r2;
    logic               ge;
    n = d;
    for (int c = 0; c < NCH; c++) begin
      r2 = {d.rem[c], d.quo[c][CB-1]};
      ge = (r2 >= {1'b0, d.dsum});
      n.rem[c] = ge ? WW'(r2 - {1'b0, d.dsum}) : r2[WW-1:0];
      n.quo[c] = {d.quo[c][CB-2:0], ge};
    end
    return n;
  endfunction

  logic [STAGES-1:0]  vld;
  aoc_pkg::div_data_t data [STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data[0] <= div_step(in_data);
      for (int k = 1; k < STAGES; k++) begin
        data[k] <= div_step(data[k-1]);
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_data  = data[STAGES-1];

endmodule

>>> rtl/core/aoc_out_stage.sv
// Final rounding, mode select and a two-entry output buffer that decouples the stall.
// Depends on aoc_pkg.
module aoc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  aoc_pkg::alpha_mode_t mode,
  input  logic                 in_valid,
  input  aoc_pkg::div_data_t   in_data,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output aoc_pkg::pixel_t      out_pixel
);

  localparam int CB  = aoc_pkg::CHANNEL_BITS;
  localparam int NCH = aoc_pkg::NCH;
  localparam int WW  = aoc_pkg::WEIGHT_W;

  aoc_pkg::chan_t [NCH-1:0] col;
  aoc_pkg::pixel_t          px;
  logic [WW:0]              rr;
  logic                     up;
  logic [CB:0]              qr;
  aoc_pkg::chan_t           st;

  always_comb begin
    rr = '0;
    up = 1'b0;
    qr = '0;
    st = '0;
    for (int c = 0; c < NCH; c++) begin
      // round half up: bump when twice the remainder reaches the divisor
      rr = {in_data.rem[c], 1'b0};
      up = (rr >= {1'b0, in_data.dsum});
      qr = {1'b0, in_data.quo[c]} + (CB+1)'(up);
      st = (qr > {1'b0, aoc_pkg::FULL_SCALE}) ? aoc_pkg::FULL_SCALE : qr[CB-1:0];
      case (mode)
        aoc_pkg::MODE_PREMULT:  col[c] = in_data.pm[c];
        aoc_pkg::MODE_STRAIGHT: col[c] = in_data.dsum_zero ? '0 : st;
        default:                col[c] = in_data.pm[c];
      endcase
    end
    px.red   = col[0];
    px.green = col[1];
    px.blue  = col[2];
    px.alpha = in_data.alpha;
  end

  // two-entry buffer: buf0 is the head
  logic [1:0]      cnt;
  aoc_pkg::pixel_t buf0;
  aoc_pkg::pixel_t buf1;
  logic            push;
  logic            pop;

  assign ready     = (cnt != 2'd2);
  assign push      = in_valid && ready;
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_pixel = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      buf0 <= px;
    end else if (cnt == 2'd2 && pop) begin
      buf0 <= buf1;
    end
    if (push && cnt == 2'd1 && !pop) begin
      buf1 <= px;
    end
  end

endmodule

>>> test/tb_alpha_over_composite.sv
`timescale 1ns / 100ps
// Self-checking testbench for alpha_over_composite: over-operator blend of RGBA pixel pairs.
// Depends on aoc_pkg, aoc_if and the RTL under rtl/core; a scoreboard class predicts each pixel.
module tb_alpha_over_composite;
  import aoc_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [ADDR_W-3:0] REG_SPARE = 1'b1;  // unmapped register index
  localparam logic [ADDR_W-1:0] MODE_ADDR = {REG_ALPHA_MODE, 2'b00};
  localparam logic [ADDR_W-1:0] SPARE_ADDR = {REG_SPARE, 2'b00};

  typedef struct packed {
    chan_t fg_red;
    chan_t fg_green;
    chan_t fg_blue;
    chan_t fg_alpha;
    chan_t bg_red;
    chan_t bg_green;
    chan_t bg_blue;
    chan_t bg_alpha;
  } rgba_pair_t;

  class blend_scoreboard;
    alpha_mode_t mode = MODE_PREMULT;
    pixel_t      pending[$];
    int          errors = 0;

    function void set_register(logic [ADDR_W-3:0] index, logic [31:0] value);
      if (index == REG_ALPHA_MODE) mode = alpha_mode_t'(value[0]);
    endfunction

    // Exact over operator, rounded half up, saturated to full scale.
    // 16-bit inputs can never exceed full scale, so no input clamp is needed.
    function pixel_t composite_over(rgba_pair_t p);
      longint unsigned m, af, ab, inv, wf, wb, dsum, v;
      longint unsigned cf[3], cb[3], res[3];
      pixel_t px;
      m = FULL_SCALE;
      af = p.fg_alpha;
      ab = p.bg_alpha;
      inv = m - af;
      wf = af * m;
      wb = ab * inv;
      dsum = wf + wb;
      cf = '{p.fg_red, p.fg_green, p.fg_blue};
      cb = '{p.bg_red, p.bg_green, p.bg_blue};
      for (int c = 0; c < 3; c++) begin
        if (mode == MODE_PREMULT)
          v = (2 * (cf[c] * m + cb[c] * inv) + m) / (2 * m);
        else if (dsum == 0)
          v = 0;
        else
          v = (2 * (cf[c] * wf + cb[c] * wb) + dsum) / (2 * dsum);
        res[c] = (v > m) ? m : v;
      end
      v = (2 * dsum + m) / (2 * m);
      if (v > m) v = m;
      px.red = chan_t'(res[0]);
      px.green = chan_t'(res[1]);
      px.blue = chan_t'(res[2]);
      px.alpha = chan_t'(v);
      return px;
    endfunction

    function void note_layers(rgba_pair_t p);
      pending.push_back(composite_over(p));
    endfunction

    function void check_field(string name, chan_t exp_val, chan_t act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_blend(pixel_t got);
      pixel_t exp_px;
      if (pending.size() == 0) begin
        $error("blended transaction with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      check_field("out_red", exp_px.red, got.red);
      check_field("out_green", exp_px.green, got.green);
      check_field("out_blue", exp_px.blue, got.blue);
      check_field("out_alpha", exp_px.alpha, got.alpha);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          send_idle_pct, recv_stall_pct, idle_cycles;

  aoc_layers_if layers_ch();
  aoc_blend_if  blend_ch();

  blend_scoreboard sb = new();

  alpha_over_composite DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .layers(layers_ch), .blended(blend_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: check each blended transaction, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && blend_ch.valid && blend_ch.ready)
      sb.check_blend('{blend_ch.out_red, blend_ch.out_green, blend_ch.out_blue,
                       blend_ch.out_alpha});
    blend_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (layers_ch.valid && layers_ch.ready) || (blend_ch.valid && blend_ch.ready) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_alpha_over_composite: FAIL");
      $finish;
    end
  end

  // returns at the clock edge after it drives the bus idle
  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(addr[ADDR_W-1:2], data);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_mode_reg();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= MODE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(sb.mode)) begin
      $error("alpha_mode: expected %0d, actual %0d", sb.mode, prdata);
      sb.errors++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [31:0] value);
    reg_write(MODE_ADDR, value);
    check_mode_reg();
  endtask

  // call at a clock edge; returns at the edge after the idle gap
  task automatic send_layers(rgba_pair_t p);
    layers_ch.valid <= 1'b1;
    layers_ch.fg_red <= p.fg_red;     layers_ch.fg_green <= p.fg_green;
    layers_ch.fg_blue <= p.fg_blue;   layers_ch.fg_alpha <= p.fg_alpha;
    layers_ch.bg_red <= p.bg_red;     layers_ch.bg_green <= p.bg_green;
    layers_ch.bg_blue <= p.bg_blue;   layers_ch.bg_alpha <= p.bg_alpha;
    @(posedge clk);
    while (!layers_ch.ready) @(posedge clk);
    sb.note_layers(p);
    while ($urandom_range(99) < send_idle_pct) begin
      layers_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    layers_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() > 0) @(posedge clk);
  endtask

  function automatic rgba_pair_t pair_of(chan_t fr, chan_t fgr, chan_t fb, chan_t fa,
                                         chan_t br, chan_t bgr, chan_t bb, chan_t ba);
    return '{fr, fgr, fb, fa, br, bgr, bb, ba};
  endfunction

  function automatic chan_t random_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return FULL_SCALE;
      2: return chan_t'($urandom_range(255));
      3: return FULL_SCALE - chan_t'($urandom_range(255));
      default: return chan_t'($urandom);
    endcase
  endfunction

  // mostly valid premultiplied pixels (colour <= alpha), some raw noise
  function automatic chan_t colour_under(chan_t alpha);
    if ($urandom_range(9) < 7) return chan_t'($urandom_range(int'(alpha)));
    return random_chan();
  endfunction

  function automatic rgba_pair_t random_pair();
    rgba_pair_t p;
    p.fg_alpha = random_chan();
    p.bg_alpha = random_chan();
    p.fg_red = colour_under(p.fg_alpha);
    p.fg_green = colour_under(p.fg_alpha);
    p.fg_blue = colour_under(p.fg_alpha);
    p.bg_red = colour_under(p.bg_alpha);
    p.bg_green = colour_under(p.bg_alpha);
    p.bg_blue = colour_under(p.bg_alpha);
    return p;
  endfunction

  task automatic run_directed();
    chan_t m;
    m = FULL_SCALE;
    send_layers(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_layers(pair_of(m, m, m, m, m, m, m, m));
    send_layers(pair_of(16'h1234, 16'hBEEF, 16'h0F0F, m, m, 16'h8000, 1, m));
    send_layers(pair_of(16'h4000, 16'h2000, 16'h1000, 0, 16'h0123, 16'hFEDC, m, m));
    // both alphas zero: straight result goes fully transparent
    send_layers(pair_of(m, 16'h7777, 1, 0, m, 16'h3333, 1, 0));
    // colour above alpha, premultiplied sum overflows full scale
    send_layers(pair_of(m, m, m, 0, m, m, m, 16'h0010));
    send_layers(pair_of(m, m, m, 1, m, m, m, m));
    send_layers(pair_of(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    send_layers(pair_of(1, 0, 1, 1, m, m, m, 0));
    send_layers(pair_of(0, 1, 0, 0, 1, 0, 1, 1));
    send_layers(pair_of(16'h8000, 16'h7FFF, 16'h4000, 16'h8000,
                        16'h7FFF, 16'h8000, 16'hC000, 16'h7FFF));
    send_layers(pair_of(m, m, m, m, 0, 0, 0, 0));
    drain();
  endtask

  task automatic run_random(logic [31:0] mode_value, int send_pct, int recv_pct, int count);
    set_mode(mode_value);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      // hold off once per phase until the pipeline is empty
      if (i == count / 2) drain();
      send_layers(random_pair());
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    layers_ch.valid <= 1'b0;
    layers_ch.fg_red <= '0; layers_ch.fg_green <= '0;
    layers_ch.fg_blue <= '0; layers_ch.fg_alpha <= '0;
    layers_ch.bg_red <= '0; layers_ch.bg_green <= '0;
    layers_ch.bg_blue <= '0; layers_ch.bg_alpha <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_mode_reg();
    run_directed();
    // upper bits must be dropped; a write to an unmapped index changes nothing
    set_mode(32'hFFFF_FFFF);
    reg_write(SPARE_ADDR, 32'h0000_0000);
    check_mode_reg();
    run_directed();

    run_random(32'h0000_0000, 0, 0, 100);
    run_random(32'h8000_0001, 0, 0, 100);
    run_random(32'hFFFF_FFFE, 64, 0, 100);
    run_random(32'h0000_0001, 0, 64, 100);
    run_random(32'h0000_0003, 19, 19, 100);
    run_random(32'h0000_0002, 19, 19, 100);
    run_random(32'h0000_0001, 64, 0, 100);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending.size() > 0) begin
      $error("%0d blended transactions never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("tb_alpha_over_composite: PASS");
    else
      $display("tb_alpha_over_composite: FAIL");
    $finish;
  end

endmodule
